// File: sv/cbd_pkg.sv
// Package with the beat types, address map constants and request codes of the CPU bus decoder.
package cbd_pkg;

	localparam int RAM_ADDR_BITS = 11;
	localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;
	localparam logic [RAM_ADDR_BITS-1:0] RAM_LAST = RAM_ADDR_BITS'(RAM_DEPTH - 1);

	// Request codes.
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// PPU access codes.
	localparam logic [1:0] PPU_NONE     = 2'd0;
	localparam logic [1:0] PPU_READ     = 2'd1;
	localparam logic [1:0] PPU_READ_DBG = 2'd2;
	localparam logic [1:0] PPU_WRITE    = 2'd3;

	// Address map.
	localparam logic [15:0] ADDR_RAM_END  = 16'h1FFF;
	localparam logic [15:0] ADDR_PPU_BASE = 16'h2000;
	localparam logic [15:0] ADDR_PPU_END  = 16'h3FFF;
	localparam logic [15:0] ADDR_DMA_PAGE = 16'h4014;
	localparam logic [15:0] ADDR_PAD0     = 16'h4016;
	localparam logic [15:0] ADDR_PAD1     = 16'h4017;

	// Tick phases.
	localparam logic [2:0] PHASE_LAST      = 3'd5;
	localparam logic [2:0] PHASE_DMA_READ  = 3'd0;
	localparam logic [2:0] PHASE_DMA_WRITE = 3'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic        read_only;
		logic        cart_hit;
		logic [7:0]  cart_data;
		logic [7:0]  ppu_data;
		logic [7:0]  pad_bits;
		logic        ppu_nmi;
	} req_beat_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [1:0]  ppu_access;
		logic [2:0]  ppu_reg;
		logic [7:0]  ppu_wdata;
		logic        oam_write;
		logic [7:0]  oam_index;
		logic [7:0]  oam_data;
		logic        cpu_step;
		logic        nmi_out;
		logic        dma_busy;
		logic [15:0] dma_source_addr;
	} rsp_beat_t;

endpackage

// File: sv/cbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/cpu_bus_decode_with_sprite_dma.sv
// Top level of the CPU bus decoder with work RAM, controller latches and sprite DMA.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req  (req_beat_t)
//   rsp      out        rsp_valid / rsp_ready  rsp  (rsp_beat_t)
//
// One beat is accepted per cycle while req_ready is high. Its result passes through the s1
// stage, which waits for the registered read of the work RAM, and then the output register
// before it leaves on rsp.
// After reset the work RAM is cleared by a sweep over all 2^RAM_ADDR_BITS entries (2048 at the
// default size), one entry per cycle, and req_ready stays low until the sweep is done.
// The s1 stage and the output register form a two-deep queue, so one new beat is taken
// while a finished result waits for rsp_ready.
module cpu_bus_decode_with_sprite_dma
	import cbd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_beat_t rsp
);

	// Small architectural state lives in flip-flops; the work RAM is a memory instance.
	logic [1:0][7:0] pad_q;
	logic [7:0]      dma_page_q;
	logic [7:0]      dma_index_q;
	logic [7:0]      dma_byte_q;
	logic            dma_active_q;
	logic            dma_wait_q;
	logic [2:0]      phase_q;

	// RAM clearing sweep after reset.
	logic                     clr_busy_q;
	logic [RAM_ADDR_BITS-1:0] clr_addr_q;

	// Pipeline: s1 waits for the RAM read, then the output register.
	logic      v_s1;
	rsp_beat_t rsp_s1;
	logic      ram_rd_s1;
	logic      dma_ld_s1;
	logic      v_q;
	rsp_beat_t rsp_q;
	rsp_beat_t rsp_out_d;

	logic accept;
	logic adv;

	// Next-state and decode results.
	rsp_beat_t                rsp_d;
	logic                     ram_rd_d;
	logic                     dma_ld_d;
	logic                     ram_we_d;
	logic                     ram_re_d;
	logic [1:0][7:0]          pad_d;
	logic [7:0]               page_d;
	logic [7:0]               idx_d;
	logic [7:0]               byte_d;
	logic                     byte_set_d;
	logic                     active_d;
	logic                     wait_d;
	logic [2:0]               phase_d;
	logic [15:0]              bus_a;
	logic                     is_ram;
	logic                     is_ppu;
	logic                     is_pad;
	logic                     is_dma;
	logic                     do_read;
	logic                     dbg_read;
	logic                     dma_rd;
	logic                     ram_hit;
	logic [7:0]               rd_val;

	logic                     mem_we;
	logic [RAM_ADDR_BITS-1:0] mem_waddr;
	logic [7:0]               mem_wdata;
	logic [7:0]               mem_rdata;

	assign adv       = v_s1 && (!v_q || rsp_ready);
	assign req_ready = !clr_busy_q && (!v_s1 || adv);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = v_q;
	assign rsp       = rsp_q;

	// A tick's DMA source read goes out on the page:index address; everything else uses addr.
	assign bus_a  = (req.req_type == REQ_TICK) ? {dma_page_q, dma_index_q} : req.addr;
	assign is_ram = bus_a <= ADDR_RAM_END;
	assign is_ppu = (bus_a >= ADDR_PPU_BASE) && (bus_a <= ADDR_PPU_END);
	assign is_pad = (bus_a == ADDR_PAD0) || (bus_a == ADDR_PAD1);
	assign is_dma = bus_a == ADDR_DMA_PAGE;

	always_comb begin
		rsp_d      = '0;
		ram_rd_d   = 1'b0;
		dma_ld_d   = 1'b0;
		ram_we_d   = 1'b0;
		ram_re_d   = 1'b0;
		pad_d      = pad_q;
		page_d     = dma_page_q;
		idx_d      = dma_index_q;
		byte_d     = dma_byte_q;
		byte_set_d = 1'b0;
		active_d   = dma_active_q;
		wait_d     = dma_wait_q;
		phase_d    = phase_q;
		do_read    = 1'b0;
		dbg_read   = 1'b0;
		dma_rd     = 1'b0;
		ram_hit    = 1'b0;
		rd_val     = '0;

		unique case (req.req_type)
			REQ_WRITE: begin
				// The cartridge swallows a write it claims.
				if (!req.cart_hit) begin
					if (is_ram) begin
						ram_we_d = 1'b1;
					end else if (is_ppu) begin
						rsp_d.ppu_access = PPU_WRITE;
						rsp_d.ppu_reg    = bus_a[2:0];
						rsp_d.ppu_wdata  = req.wdata;
					end else if (is_dma) begin
						// A restart keeps the alignment wait flag as it is.
						page_d   = req.wdata;
						idx_d    = '0;
						active_d = 1'b1;
					end else if (is_pad) begin
						pad_d[bus_a[0]] = req.pad_bits;
					end
				end
			end
			REQ_READ: begin
				do_read  = 1'b1;
				dbg_read = req.read_only;
			end
			REQ_TICK: begin
				rsp_d.nmi_out = req.ppu_nmi;
				phase_d = (phase_q == PHASE_LAST) ? 3'd0 : phase_q + 3'd1;
				if (phase_q == PHASE_DMA_READ || phase_q == PHASE_DMA_WRITE) begin
					if (dma_active_q) begin
						if (dma_wait_q) begin
							// The wait clears only on the odd half of the CPU cycle.
							if (phase_q == PHASE_DMA_WRITE) begin
								wait_d = 1'b0;
							end
						end else if (phase_q == PHASE_DMA_READ) begin
							do_read = 1'b1;
							dma_rd  = 1'b1;
						end else begin
							rsp_d.oam_write = 1'b1;
							rsp_d.oam_index = dma_index_q;
							rsp_d.oam_data  = dma_byte_q;
							idx_d           = dma_index_q + 8'd1;
							if (dma_index_q == 8'hFF) begin
								active_d = 1'b0;
								wait_d   = 1'b1;
							end
						end
					end else begin
						rsp_d.cpu_step = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		// Shared read decode for CPU reads and DMA source reads.
		if (do_read) begin
			if (req.cart_hit) begin
				rd_val = req.cart_data;
			end else if (is_ram) begin
				ram_re_d = 1'b1;
				ram_hit  = 1'b1;
			end else if (is_ppu) begin
				rsp_d.ppu_access = dbg_read ? PPU_READ_DBG : PPU_READ;
				rsp_d.ppu_reg    = bus_a[2:0];
				rd_val           = req.ppu_data;
			end else if (is_pad) begin
				// The latch shifts even on a debug read.
				rd_val          = {7'd0, pad_q[bus_a[0]][7]};
				pad_d[bus_a[0]] = {pad_q[bus_a[0]][6:0], 1'b0};
			end
		end

		if (req.req_type == REQ_READ) begin
			rsp_d.read_data = rd_val;
			ram_rd_d        = ram_hit;
		end
		if (dma_rd) begin
			byte_d     = rd_val;
			byte_set_d = !ram_hit;
			dma_ld_d   = ram_hit;
		end

		rsp_d.dma_busy        = active_d;
		rsp_d.dma_source_addr = {page_d, idx_d};
	end

	// The clearing sweep owns the write port until it finishes.
	assign mem_we    = clr_busy_q || (accept && ram_we_d);
	assign mem_waddr = clr_busy_q ? clr_addr_q : req.addr[RAM_ADDR_BITS-1:0];
	assign mem_wdata = clr_busy_q ? 8'd0 : req.wdata;

	cbd_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_work_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept && ram_re_d),
		.raddr (bus_a[RAM_ADDR_BITS-1:0]),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q        <= '0;
			dma_page_q   <= '0;
			dma_index_q  <= '0;
			dma_byte_q   <= '0;
			dma_active_q <= 1'b0;
			dma_wait_q   <= 1'b1;
			phase_q      <= '0;
			clr_busy_q   <= 1'b1;
			clr_addr_q   <= '0;
			v_s1         <= 1'b0;
			ram_rd_s1    <= 1'b0;
			dma_ld_s1    <= 1'b0;
			v_q          <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + RAM_ADDR_BITS'(1);
				if (clr_addr_q == RAM_LAST) begin
					clr_busy_q <= 1'b0;
				end
			end

			// A DMA byte read from RAM lands when its beat leaves s1. The next DMA read
			// is at least six ticks away, so it never collides with a direct load below.
			if (adv && dma_ld_s1) begin
				dma_byte_q <= mem_rdata;
			end

			if (accept) begin
				pad_q        <= pad_d;
				dma_page_q   <= page_d;
				dma_index_q  <= idx_d;
				dma_active_q <= active_d;
				dma_wait_q   <= wait_d;
				phase_q      <= phase_d;
				if (byte_set_d) begin
					dma_byte_q <= byte_d;
				end
				ram_rd_s1 <= ram_rd_d;
				dma_ld_s1 <= dma_ld_d;
			end

			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end

			if (adv) begin
				v_q <= 1'b1;
			end else if (rsp_ready) begin
				v_q <= 1'b0;
			end
		end
	end

	// A CPU read of work RAM takes its byte from the RAM output as it leaves s1.
	always_comb begin
		rsp_out_d = rsp_s1;
		if (ram_rd_s1) begin
			rsp_out_d.read_data = mem_rdata;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_s1 <= rsp_d;
		end
		if (adv) begin
			rsp_q <= rsp_out_d;
		end
	end

endmodule

// File: bench/tb.sv
// Self-checking testbench for the CPU bus decoder with sprite DMA.
module tb;
	import cbd_pkg::*;

	// Request code that the block must treat as a no-op.
	localparam logic [1:0] REQ_NONE = 2'd3;

	// The run is stopped by force after this many clock cycles.
	localparam int CYCLE_LIMIT = 200_000;
	// Mismatch lines printed at most; further mismatches are only counted.
	localparam int MAX_REPORTS = 40;
	// The receiver holds off once, for this many cycles, after this many results.
	localparam int HOLDOFF_CYCLES = 300;
	localparam int HOLDOFF_AFTER  = 80;
	// Ticks that follow the DMA start of the long transfer. A full transfer needs at most
	// six ticks for the alignment wait plus 256 read/write pairs of six ticks each.
	localparam int TRANSFER_TICKS = 1550;

	typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_SLOW} rx_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_beat_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_beat_t rsp;

	cpu_bus_decode_with_sprite_dma i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Request beats waiting to be offered, and the results predicted for accepted beats.
	req_beat_t pending_reqs[$];
	rsp_beat_t expected_rsps[$];

	// Shadow copy of the block's state, advanced once per accepted request beat.
	logic [7:0] shadow_ram [RAM_DEPTH];
	logic [7:0] pad_latch [2];
	logic [7:0] spr_page = '0;
	logic [7:0] spr_index = '0;
	logic [7:0] spr_byte = '0;
	logic       spr_running = 1'b0;
	logic       spr_align_wait = 1'b1;
	logic [2:0] phase_ctr = '0;

	int n_errors = 0;
	int n_checked = 0;
	int n_oam_bytes = 0;
	int n_transfers = 0;
	int n_restarts = 0;
	int rsps_seen = 0;
	logic req_took = 1'b0;

	// Decoded read with side effects, shared by CPU reads and the DMA source read. A PPU
	// read is reported in the result; a controller read shifts its latch.
	function automatic logic [7:0] bus_fetch(input logic [15:0] a, input logic dbg,
			input req_beat_t b, inout rsp_beat_t r);
		logic [7:0] v;
		v = '0;
		if (b.cart_hit) begin
			v = b.cart_data;
		end else if (a <= ADDR_RAM_END) begin
			v = shadow_ram[a[RAM_ADDR_BITS-1:0]];
		end else if (a >= ADDR_PPU_BASE && a <= ADDR_PPU_END) begin
			r.ppu_access = dbg ? PPU_READ_DBG : PPU_READ;
			r.ppu_reg = a[2:0];
			v = b.ppu_data;
		end else if (a == ADDR_PAD0 || a == ADDR_PAD1) begin
			v = {7'd0, pad_latch[a[0]][7]};
			pad_latch[a[0]] = pad_latch[a[0]] << 1;
		end
		return v;
	endfunction

	// Works out the result of one request beat and advances the shadow state.
	function automatic rsp_beat_t predict_beat(input req_beat_t b);
		rsp_beat_t  r;
		logic [2:0] ph;
		logic [7:0] rd;
		r = '0;
		case (b.req_type)
			REQ_WRITE: begin
				if (!b.cart_hit) begin
					if (b.addr <= ADDR_RAM_END) begin
						shadow_ram[b.addr[RAM_ADDR_BITS-1:0]] = b.wdata;
					end else if (b.addr >= ADDR_PPU_BASE && b.addr <= ADDR_PPU_END) begin
						r.ppu_access = PPU_WRITE;
						r.ppu_reg = b.addr[2:0];
						r.ppu_wdata = b.wdata;
					end else if (b.addr == ADDR_DMA_PAGE) begin
						// A start while a transfer runs restarts it but keeps the
						// alignment wait flag as it is.
						if (spr_running)
							n_restarts++;
						spr_page = b.wdata;
						spr_index = '0;
						spr_running = 1'b1;
					end else if (b.addr == ADDR_PAD0 || b.addr == ADDR_PAD1) begin
						pad_latch[b.addr[0]] = b.pad_bits;
					end
				end
			end
			REQ_READ: begin
				rd = bus_fetch(b.addr, b.read_only, b, r);
				r.read_data = rd;
			end
			REQ_TICK: begin
				ph = phase_ctr;
				if (ph == PHASE_DMA_READ || ph == PHASE_DMA_WRITE) begin
					if (!spr_running) begin
						r.cpu_step = 1'b1;
					end else if (spr_align_wait) begin
						// The wait ends only on the write phase, so the first source
						// read falls on a read phase.
						if (ph == PHASE_DMA_WRITE)
							spr_align_wait = 1'b0;
					end else if (ph == PHASE_DMA_READ) begin
						spr_byte = bus_fetch({spr_page, spr_index}, 1'b0, b, r);
					end else begin
						r.oam_write = 1'b1;
						r.oam_index = spr_index;
						r.oam_data = spr_byte;
						n_oam_bytes++;
						spr_index = spr_index + 8'd1;
						if (spr_index == 8'd0) begin
							spr_running = 1'b0;
							spr_align_wait = 1'b1;
							n_transfers++;
						end
					end
				end
				r.nmi_out = b.ppu_nmi;
				phase_ctr = (ph == PHASE_LAST) ? 3'd0 : ph + 3'd1;
			end
			default: begin
			end
		endcase
		r.dma_busy = spr_running;
		r.dma_source_addr = {spr_page, spr_index};
		return r;
	endfunction

	task automatic field_check(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			n_errors++;
			if (n_errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	task automatic compare_beat(input rsp_beat_t want, input rsp_beat_t got);
		field_check("read_data", 16'(want.read_data), 16'(got.read_data));
		field_check("ppu_access", 16'(want.ppu_access), 16'(got.ppu_access));
		field_check("ppu_reg", 16'(want.ppu_reg), 16'(got.ppu_reg));
		field_check("ppu_wdata", 16'(want.ppu_wdata), 16'(got.ppu_wdata));
		field_check("oam_write", 16'(want.oam_write), 16'(got.oam_write));
		field_check("oam_index", 16'(want.oam_index), 16'(got.oam_index));
		field_check("oam_data", 16'(want.oam_data), 16'(got.oam_data));
		field_check("cpu_step", 16'(want.cpu_step), 16'(got.cpu_step));
		field_check("nmi_out", 16'(want.nmi_out), 16'(got.nmi_out));
		field_check("dma_busy", 16'(want.dma_busy), 16'(got.dma_busy));
		field_check("dma_source_addr", want.dma_source_addr, got.dma_source_addr);
	endtask

	// A beat of the given kind and address with every other field random. The cartridge
	// claims about one beat in five so that the address decode is reached most of the time.
	function automatic req_beat_t scramble_beat(input logic [1:0] kind, input logic [15:0] a);
		req_beat_t b;
		b.req_type  = kind;
		b.addr      = a;
		b.wdata     = 8'($urandom_range(0, 255));
		b.read_only = 1'($urandom_range(0, 1));
		b.cart_hit  = ($urandom_range(0, 4) == 0);
		b.cart_data = 8'($urandom_range(0, 255));
		b.ppu_data  = 8'($urandom_range(0, 255));
		b.pad_bits  = 8'($urandom_range(0, 255));
		b.ppu_nmi   = 1'($urandom_range(0, 1));
		return b;
	endfunction

	// Addresses weighted toward the decoded regions, the rest spread over the whole map.
	function automatic logic [15:0] pick_addr();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 35)
			return 16'($urandom_range(0, ADDR_RAM_END));
		if (sel < 55)
			return 16'($urandom_range(ADDR_PPU_BASE, ADDR_PPU_END));
		if (sel < 65)
			return sel[0] ? ADDR_PAD1 : ADDR_PAD0;
		if (sel < 70)
			return ADDR_DMA_PAGE;
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic req_beat_t mixed_beat();
		int unsigned sel;
		logic [1:0]  kind;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			kind = REQ_TICK;
		else if (sel < 68)
			kind = REQ_READ;
		else if (sel < 97)
			kind = REQ_WRITE;
		else
			kind = REQ_NONE;
		return scramble_beat(kind, pick_addr());
	endfunction

	// DMA source pages from work RAM, the PPU window, the I/O page with the controller
	// latches, or anywhere.
	function automatic logic [7:0] pick_page();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(8'h00, 8'h1F));
			1: return 8'($urandom_range(8'h20, 8'h3F));
			2: return 8'h40;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic queue_beat(input logic [1:0] kind, input logic [15:0] a,
			input logic [7:0] wd, input logic ro, input logic hit,
			input logic [7:0] pads, input logic nmi);
		req_beat_t b;
		b = scramble_beat(kind, a);
		b.wdata = wd;
		b.read_only = ro;
		b.cart_hit = hit;
		b.pad_bits = pads;
		b.ppu_nmi = nmi;
		pending_reqs.push_back(b);
	endtask

	// Monitor. Sampling happens at the rising edge, where every input driven at the
	// falling edge is stable and outputs still hold their pre-edge values. A request beat
	// that is accepted here is run through the predictor at once, so the queue of
	// expectations is always in acceptance order.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_took <= 1'b0;
		end else begin
			req_took <= req_valid && req_ready;
			if (req_valid && req_ready)
				expected_rsps.push_back(predict_beat(req));
			if (rsp_valid && rsp_ready) begin
				rsps_seen++;
				if (expected_rsps.size() == 0) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t: result beat with nothing expected, expected none, got %h",
							$time, rsp);
				end else begin
					compare_beat(expected_rsps.pop_front(), rsp);
					n_checked++;
				end
			end
		end
	end

	// Driver. The sender offers beats in bursts of random length separated by random
	// gaps; about one burst in four runs straight into the next with no gap at all. A
	// beat stays on the bus, unchanged, until the monitor has seen it accepted.
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && !req_took) begin
			// Still waiting for the block to take the current beat.
		end else if (gap_left != 0) begin
			gap_left--;
			req_valid <= 1'b0;
		end else if (pending_reqs.size() != 0) begin
			req <= pending_reqs.pop_front();
			req_valid <= 1'b1;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			end else begin
				burst_left--;
			end
		end else begin
			req_valid <= 1'b0;
		end
	end

	// Receiver. It switches between free-running, half-rate and mostly stalled stretches
	// of random length. Once, after some results have arrived, it holds rsp_ready low for
	// a long stretch while the sender keeps offering beats, so the block has to fill its
	// internal queue and push back on req_ready.
	rx_mode_t rx_mode = RX_FREE;
	int       mode_left = 0;
	int       hold_left = 0;
	logic     hold_done = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (!hold_done && rsps_seen >= HOLDOFF_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLDOFF_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (rx_mode)
				RX_FREE: rsp_ready <= 1'b1;
				RX_HALF: rsp_ready <= 1'($urandom_range(0, 1));
				default: rsp_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Watchdog. The slowest legal run is the RAM clearing sweep plus about two thousand
	// beats, each at worst paying a sender gap and a slow receiver, plus the long hold-off;
	// that stays well below the limit.
	int cycles = 0;

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: timeout after %0d cycles, %0d results still expected",
			cycles, expected_rsps.size());
		$display("tb: done, errors");
		$finish;
	end

	// Stimulus and end of run.
	initial begin
		req_beat_t b;
		int        ticks;

		for (int i = 0; i < RAM_DEPTH; i++)
			shadow_ram[i] = '0;
		pad_latch[0] = '0;
		pad_latch[1] = '0;

		// Directed part: RAM mirrors, PPU window edges, cartridge claims, controller
		// latches, unmapped and unknown requests, NMI forwarding and a DMA restart.
		queue_beat(REQ_READ, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
		queue_beat(REQ_WRITE, 16'h07FF, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_beat(REQ_READ, ADDR_RAM_END, 8'h00, 1'b1, 1'b0, 8'hFF, 1'b0);
		queue_beat(REQ_WRITE, 16'h0800, 8'hA5, 1'b1, 1'b0, 8'h00, 1'b1);
		queue_beat(REQ_READ, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_beat(REQ_WRITE, ADDR_PPU_BASE, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_beat(REQ_WRITE, ADDR_PPU_END, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_beat(REQ_READ, 16'h2007, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_beat(REQ_READ, 16'h3FF8, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0);
		// The cartridge swallows the write and answers the read; RAM keeps its byte.
		queue_beat(REQ_WRITE, 16'h0000, 8'h11, 1'b0, 1'b1, 8'h00, 1'b0);
		queue_beat(REQ_READ, 16'h0000, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
		queue_beat(REQ_READ, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		// Controller latches load from the live buttons; the written byte is ignored.
		queue_beat(REQ_WRITE, ADDR_PAD0, 8'hFF, 1'b0, 1'b0, 8'h80, 1'b0);
		queue_beat(REQ_WRITE, ADDR_PAD1, 8'h00, 1'b0, 1'b0, 8'h7F, 1'b0);
		queue_beat(REQ_READ, ADDR_PAD0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_beat(REQ_READ, ADDR_PAD0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_beat(REQ_READ, ADDR_PAD1, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0);
		queue_beat(REQ_READ, ADDR_PAD1, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0);
		// Nothing claims these.
		queue_beat(REQ_READ, ADDR_DMA_PAGE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_beat(REQ_READ, 16'hFFFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_beat(REQ_WRITE, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 8'hFF, 1'b0);
		queue_beat(REQ_NONE, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1);
		// A DMA from page zero, restarted from the PPU window mid-way.
		queue_beat(REQ_WRITE, ADDR_DMA_PAGE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		for (int i = 0; i < 14; i++)
			queue_beat(REQ_TICK, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, i[0]);
		queue_beat(REQ_WRITE, ADDR_DMA_PAGE, 8'h20, 1'b0, 1'b0, 8'h00, 1'b0);
		for (int i = 0; i < 8; i++)
			queue_beat(REQ_TICK, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, i[1]);

		// Random mix; DMA starts and restarts come up now and then.
		for (int i = 0; i < 120; i++)
			pending_reqs.push_back(mixed_beat());

		// One transfer run to its end, with CPU accesses and no-ops mixed in between
		// the ticks. Nothing in between may touch the DMA page register.
		b = scramble_beat(REQ_WRITE, ADDR_DMA_PAGE);
		b.cart_hit = 1'b0;
		b.wdata = pick_page();
		pending_reqs.push_back(b);
		ticks = 0;
		while (ticks < TRANSFER_TICKS) begin
			if ($urandom_range(0, 9) == 0) begin
				b = mixed_beat();
				if (b.addr == ADDR_DMA_PAGE)
					b.req_type = REQ_READ;
			end else begin
				b = scramble_beat(REQ_TICK, pick_addr());
			end
			if (b.req_type == REQ_TICK)
				ticks++;
			pending_reqs.push_back(b);
		end

		// More random mix, now starting from the idle state that a finished transfer
		// leaves behind.
		for (int i = 0; i < 80; i++)
			pending_reqs.push_back(mixed_beat());

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		// Let a stray late result show up before the verdict.
		repeat (8) @(posedge clk);

		$display("tb: %0d result beats checked, %0d mismatches", n_checked, n_errors);
		$display("tb: DMA wrote %0d sprite bytes, %0d transfers ran to the end, %0d restarts",
			n_oam_bytes, n_transfers, n_restarts);
		if (n_errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// File: cpu_bus_decode_with_sprite_dma.f
sv/cbd_pkg.sv
sv/cbd_ram.sv
sv/cpu_bus_decode_with_sprite_dma.sv
bench/tb.sv
